>>> design/ahlr_pkg.sv
// ----------------------------------------------------------------------------
// ahlr_pkg: shared types and constants for the headlamp light request
// Register map, register file type and fixed limits of the light decision.
// ----------------------------------------------------------------------------
package ahlr_pkg;

    localparam int LEVEL_W = 12;
    localparam int GEAR_W  = 3;
    localparam int DELAY_W = 8;
    localparam int FCNT_W  = 6;
    localparam int TH_W    = LEVEL_W + 1;   // raised thresholds do not wrap
    localparam int GEARS   = 5;

    localparam logic [LEVEL_W-1:0] FULL_SCALE    = 12'hFFF;
    localparam logic [LEVEL_W-1:0] CLIP_LEVEL    = 12'hFFE;
    localparam logic [FCNT_W-1:0]  FAULT_TICKS   = 6'd50;
    localparam logic [LEVEL_W-1:0] UP_LOW_LIMIT  = 12'd50;
    localparam logic [LEVEL_W-1:0] UP_MID_LIMIT  = 12'd80;
    localparam logic [LEVEL_W-1:0] UP_BRIGHT_MIN = 12'd64;
    localparam logic [LEVEL_W-1:0] FW_BRIGHT_ABS = 12'd300;
    localparam logic [TH_W-1:0]    STEP_MID      = 13'd10;
    localparam logic [TH_W-1:0]    STEP_HIGH     = 13'd20;

    localparam logic [GEAR_W-1:0]  TOP_GEAR      = 3'd4;

    // register indexes on the configuration port
    typedef enum logic [2:0] {
        REG_OFF_DELAY  = 3'd0,
        REG_ON_TH      = 3'd1,
        REG_OFF_TH     = 3'd2,
        REG_ON_GEAR0   = 3'd3,
        REG_ON_GEAR1   = 3'd4,
        REG_ON_GEAR2   = 3'd5,
        REG_ON_GEAR3   = 3'd6,
        REG_ON_GEAR4   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [DELAY_W-1:0]            off_delay;
        logic [LEVEL_W-1:0]            on_th;
        logic [LEVEL_W-1:0]            off_th;
        logic [GEARS-1:0][DELAY_W-1:0] on_delay;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        off_delay: 8'd55,
        on_th:     12'd100,
        off_th:    12'd150,
        on_delay:  {8'd7, 8'd9, 8'd10, 8'd5, 8'd5}
    };

endpackage

>>> design/ahlr_cfg_regs.sv
// ----------------------------------------------------------------------------
// ahlr_cfg_regs: configuration register file
// Eight registers written by index; always ready.
// ----------------------------------------------------------------------------
module ahlr_cfg_regs
    import ahlr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [2:0]         wr_index,
    input  logic [LEVEL_W-1:0] wr_data,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx_t'(wr_index))
                REG_OFF_DELAY: cfg_next.off_delay   = wr_data[DELAY_W-1:0];
                REG_ON_TH:     cfg_next.on_th       = wr_data;
                REG_OFF_TH:    cfg_next.off_th      = wr_data;
                REG_ON_GEAR0:  cfg_next.on_delay[0] = wr_data[DELAY_W-1:0];
                REG_ON_GEAR1:  cfg_next.on_delay[1] = wr_data[DELAY_W-1:0];
                REG_ON_GEAR2:  cfg_next.on_delay[2] = wr_data[DELAY_W-1:0];
                REG_ON_GEAR3:  cfg_next.on_delay[3] = wr_data[DELAY_W-1:0];
                REG_ON_GEAR4:  cfg_next.on_delay[4] = wr_data[DELAY_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RESET;
        else
            cfg_reg <= cfg_next;
    end

    assign cfg = cfg_reg;

endmodule

>>> design/ahlr_fault.sv
// ----------------------------------------------------------------------------
// ahlr_fault: stuck-at-full-scale detector for one sensor
// Counts full-scale readings; flag is set once the count has reached its limit.
// ----------------------------------------------------------------------------
module ahlr_fault
    import ahlr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [LEVEL_W-1:0] level,
    output logic               fault     // flag after this tick
);

    logic [FCNT_W-1:0] count_reg;
    logic [FCNT_W-1:0] count_next;
    logic              flag_reg;
    logic              flag_next;

    always_comb
    begin
        count_next = count_reg;
        flag_next  = flag_reg;
        if (level == FULL_SCALE)
        begin
            if (count_reg >= FAULT_TICKS)
                flag_next = 1'b1;
            else
                count_next = count_reg + 1'b1;
        end
        else
        begin
            count_next = '0;
            flag_next  = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flag_reg  <= 1'b0;
        end
        else if (step)
        begin
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

    assign fault = flag_next;

endmodule

>>> design/ahlr_decide.sv
// ----------------------------------------------------------------------------
// ahlr_decide: dark/bright classification and debounced light request
// Threshold offsets by upward level, gear-selected on delay, sticky request.
// ----------------------------------------------------------------------------
module ahlr_decide
    import ahlr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [LEVEL_W-1:0] forward_level,
    input  logic [LEVEL_W-1:0] upward_level,
    input  logic [GEAR_W-1:0]  speed_gear,
    input  logic               upward_fault,
    input  cfg_t               cfg,
    output logic               light_request   // request after this tick
);

    logic [LEVEL_W-1:0] fw;
    logic [LEVEL_W-1:0] up;
    logic [TH_W-1:0]    on_th;
    logic [TH_W-1:0]    off_th;
    logic [TH_W-1:0]    step_add;
    logic               dark;
    logic               bright;
    logic [DELAY_W-1:0] on_wait;

    logic [DELAY_W-1:0] dark_count_reg;
    logic [DELAY_W-1:0] dark_count_next;
    logic [DELAY_W-1:0] bright_count_reg;
    logic [DELAY_W-1:0] bright_count_next;
    logic               request_reg;
    logic               request_next;

    assign fw = (forward_level > CLIP_LEVEL) ? CLIP_LEVEL : forward_level;
    assign up = (upward_level > CLIP_LEVEL) ? CLIP_LEVEL : upward_level;

    always_comb
    begin
        priority if (up <= UP_LOW_LIMIT)
            step_add = '0;
        else if (up <= UP_MID_LIMIT)
            step_add = STEP_MID;
        else
            step_add = STEP_HIGH;
    end

    assign on_th  = {1'b0, cfg.on_th}  + step_add;
    assign off_th = {1'b0, cfg.off_th} + step_add;

    always_comb
    begin
        if (!upward_fault)
        begin
            dark   = ({1'b0, fw} <= on_th) && (up <= UP_LOW_LIMIT);
            bright = (({1'b0, fw} > off_th) && (up > UP_BRIGHT_MIN))
                     || (fw > FW_BRIGHT_ABS);
        end
        else
        begin
            dark   = {1'b0, fw} <= on_th;
            bright = {1'b0, fw} > off_th;
        end
    end

    // gears above the top one use the top gear's delay
    always_comb
    begin
        priority case (speed_gear)
            3'd0:    on_wait = cfg.on_delay[0];
            3'd1:    on_wait = cfg.on_delay[1];
            3'd2:    on_wait = cfg.on_delay[2];
            3'd3:    on_wait = cfg.on_delay[3];
            default: on_wait = cfg.on_delay[TOP_GEAR];
        endcase
    end

    always_comb
    begin
        dark_count_next   = dark_count_reg;
        bright_count_next = bright_count_reg;
        request_next      = request_reg;
        priority if (dark)
        begin
            bright_count_next = '0;
            if (dark_count_reg >= on_wait)
                request_next = 1'b1;
            else
                dark_count_next = dark_count_reg + 1'b1;
        end
        else if (bright)
        begin
            dark_count_next = '0;
            if (bright_count_reg >= cfg.off_delay)
                request_next = 1'b0;
            else
                bright_count_next = bright_count_reg + 1'b1;
        end
        else
        begin
            dark_count_next   = '0;
            bright_count_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dark_count_reg   <= '0;
            bright_count_reg <= '0;
            request_reg      <= 1'b0;
        end
        else if (step)
        begin
            dark_count_reg   <= dark_count_next;
            bright_count_reg <= bright_count_next;
            request_reg      <= request_next;
        end
    end

    assign light_request = request_next;

endmodule

>>> design/auto_headlamp_light_request.sv
// ----------------------------------------------------------------------------
// auto_headlamp_light_request: automatic low-beam request from light sensors
// Fault tracking on both sensors, upward-level threshold offsets, debounced
// sticky request with a gear-selected on delay.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                       width
//  s_axis    in   forward_level, upward_level, speed_gear       32 (27 used)
//  m_axis    out  light_request, forward_fault, upward_fault    8 (3 used)
//  cfg       in   cfg_index (register 0..7), cfg_data           3 + 12
//
//  One beat per cycle sustained while the output is not stalled; a beat passes
//  the input register, then the result register. The work of a beat sits in
//  one combinational pass between those registers.
//  Reset clears all counters and flags and loads the register defaults;
//  light request is off afterwards. An output stall holds the result register
//  and the input register keeps taking a beat while it is empty.
// ----------------------------------------------------------------------------
module auto_headlamp_light_request
    import ahlr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [11:0] forward_level, [23:12] upward_level, [26:24] speed_gear
    input  logic [31:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [0] light_request, [1] forward_fault, [2] upward_fault
    output logic [7:0]  m_axis_tdata,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    // input register
    logic               in_valid_reg;
    logic [LEVEL_W-1:0] in_fwd_reg;
    logic [LEVEL_W-1:0] in_up_reg;
    logic [GEAR_W-1:0]  in_gear_reg;

    // result register
    logic               out_valid_reg;
    logic               out_req_reg;
    logic               out_ffault_reg;
    logic               out_ufault_reg;

    logic               advance;     // input beat moves into result register
    logic               in_take;
    cfg_t               cfg;
    logic               fwd_fault;
    logic               up_fault;
    logic               request;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    ahlr_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ahlr_fault u_fwd_fault
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .level (in_fwd_reg),
        .fault (fwd_fault)
    );

    ahlr_fault u_up_fault
    (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (advance),
        .level (in_up_reg),
        .fault (up_fault)
    );

    // upward flag feeds the decision of the same tick
    ahlr_decide u_decide
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .forward_level (in_fwd_reg),
        .upward_level  (in_up_reg),
        .speed_gear    (in_gear_reg),
        .upward_fault  (up_fault),
        .cfg           (cfg),
        .light_request (request)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_fwd_reg  <= s_axis_tdata[11:0];
            in_up_reg   <= s_axis_tdata[23:12];
            in_gear_reg <= s_axis_tdata[26:24];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            out_req_reg    <= 1'b0;
            out_ffault_reg <= 1'b0;
            out_ufault_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg  <= 1'b1;
                out_req_reg    <= request;
                out_ffault_reg <= fwd_fault;
                out_ufault_reg <= up_fault;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'b0, out_ufault_reg, out_ffault_reg, out_req_reg};

`ifndef SYNTHESIS
    // a reading below full scale always clears that sensor's flag
    a_fwd_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_fwd_reg != FULL_SCALE) |=> !out_ffault_reg)
        else $error("forward fault flag survived a healthy reading");

    a_up_clear: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_up_reg != FULL_SCALE) |=> !out_ufault_reg)
        else $error("upward fault flag survived a healthy reading");

    // input side only stalls when both registers are full and output is held
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled without a full pipeline");

    // the request in the result register only changes on a beat moving through
    a_req_change: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(out_req_reg))
        else $error("light request changed without a beat");
`endif

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for the automatic headlamp light request
// A table of directed beats runs first: reset state, debounce edges, the
// threshold bands, gear saturation, and both sensors stuck at full scale.
// Random runs of dark, bright, dim, stuck and noise beats follow, over
// several register settings and idle patterns. Every result beat is checked
// against its hand-typed result or a cycle-free behavioural predictor of the block.
// ----------------------------------------------------------------------------
module tb
    import ahlr_pkg::*;
();

    localparam int PHASES         = 6;
    localparam int PHASE_BEATS    = 300;
    localparam int HOLD_CYCLES    = 200;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
    localparam int TAIL_CYCLES    = 4;     // two-stage pipe plus margin
    localparam int REPORT_CAP     = 100;

    // kinds of random run; well-formed runs push the debounce counters deep
    typedef enum int {
        RUN_DARK,
        RUN_BRIGHT,
        RUN_DIM,
        RUN_STUCK_FW,
        RUN_STUCK_UP,
        RUN_NOISE
    } run_kind_t;

    // register settings visited by the random phases
    typedef enum int {
        SET_MODERATE,
        SET_ZERO,
        SET_MAX,
        SET_DEFAULT,
        SET_WIDE
    } setting_t;

    // expected result typed in by hand, or left to the predictor
    typedef struct packed {
        logic       fixed;
        logic [7:0] res;
    } pinned_t;

    typedef struct packed {
        logic [11:0] fw;
        logic [11:0] up;
        logic [2:0]  gear;
        logic [7:0]  reps;
        logic        fixed;
        logic [7:0]  res;
    } dir_row_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;

    auto_headlamp_light_request u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // predictor state: own copy of the registers, counters and flags
    // ------------------------------------------------------------------
    cfg_t        lamp_cfg     = CFG_RESET;
    logic [7:0]  dark_run     = '0;
    logic [7:0]  bright_run   = '0;
    logic [5:0]  fw_stuck_cnt = '0;
    logic [5:0]  up_stuck_cnt = '0;
    logic        fw_fault     = 1'b0;
    logic        up_fault     = 1'b0;
    logic        beam_on      = 1'b0;

    logic [7:0]  lamp_exp_q [$];   // expected result beats, oldest first
    pinned_t     pinned_q   [$];   // hand-typed results, one per input beat

    int          err_cnt      = 0;
    int          tx_idle_pct  = 0;
    int          rx_idle_pct  = 0;
    int          rx_hold_left = 0;
    int          quiet_cycles = 0;

    // directed table; res packs light_request, forward_fault, upward_fault
    dir_row_t dir_tab [0:23] = '{
        // after reset, gear 0 on delay 5: five dark beats count up, sixth turns on
        '{12'd0,    12'd0,    3'd0, 8'd5,  1'b1, 8'h00},
        '{12'd0,    12'd0,    3'd0, 8'd1,  1'b1, 8'h01},
        // both sensors at full scale: fifty beats counting, gear 7 saturates
        '{12'd4095, 12'd4095, 3'd7, 8'd50, 1'b1, 8'h01},
        // fifty-first beat sets both fault flags, still bright
        '{12'd4095, 12'd4095, 3'd7, 8'd1,  1'b1, 8'h07},
        '{12'd4095, 12'd4095, 3'd7, 8'd4,  1'b1, 8'h07},
        // bright count reaches the off delay of 55
        '{12'd4095, 12'd4095, 3'd7, 8'd1,  1'b1, 8'h06},
        // one beat below full scale clears both faults
        '{12'd4094, 12'd4094, 3'd0, 8'd1,  1'b1, 8'h00},
        // threshold bands and their edges
        '{12'd100,  12'd50,   3'd1, 8'd1,  1'b0, 8'h00},
        '{12'd101,  12'd50,   3'd1, 8'd1,  1'b0, 8'h00},
        '{12'd110,  12'd51,   3'd1, 8'd1,  1'b0, 8'h00},
        '{12'd161,  12'd65,   3'd1, 8'd1,  1'b0, 8'h00},
        '{12'd161,  12'd64,   3'd1, 8'd1,  1'b0, 8'h00},
        '{12'd171,  12'd81,   3'd1, 8'd1,  1'b0, 8'h00},
        '{12'd170,  12'd81,   3'd1, 8'd1,  1'b0, 8'h00},
        '{12'd301,  12'd0,    3'd1, 8'd1,  1'b0, 8'h00},
        '{12'd300,  12'd0,    3'd1, 8'd1,  1'b0, 8'h00},
        // gear-selected on delays
        '{12'd0,    12'd0,    3'd2, 8'd12, 1'b0, 8'h00},
        '{12'd400,  12'd100,  3'd0, 8'd10, 1'b0, 8'h00},
        '{12'd0,    12'd0,    3'd3, 8'd11, 1'b0, 8'h00},
        // upward sensor stuck until faulted, then dark and bright from the forward level only; gears 6 and 7 dark
        '{12'd120,  12'd4095, 3'd4, 8'd60, 1'b0, 8'h00},
        '{12'd171,  12'd4095, 3'd5, 8'd5,  1'b0, 8'h00},
        '{12'd0,    12'd0,    3'd6, 8'd10, 1'b0, 8'h00},
        '{12'd0,    12'd0,    3'd7, 8'd10, 1'b0, 8'h00},
        // single forward full-scale beat, clipped and bright
        '{12'd4095, 12'd0,    3'd0, 8'd1,  1'b0, 8'h00}
    };

    // one tick of the light decision; updates the predictor state
    task automatic headlamp_step(input logic [11:0] fw_in, input logic [11:0] up_in,
                                 input logic [2:0] gear_in, output logic [7:0] res);
        logic [11:0]     fw;
        logic [11:0]     up;
        logic [TH_W-1:0] on_th;
        logic [TH_W-1:0] off_th;
        logic [2:0]      g;
        logic [7:0]      on_wait;
        logic            dark;
        logic            bright;

        // fault flags settle before the decision of the same tick
        if (fw_in == FULL_SCALE) begin
            if (fw_stuck_cnt >= FAULT_TICKS)
                fw_fault = 1'b1;
            else
                fw_stuck_cnt = fw_stuck_cnt + 1'b1;
        end
        else begin
            fw_stuck_cnt = '0;
            fw_fault     = 1'b0;
        end
        if (up_in == FULL_SCALE) begin
            if (up_stuck_cnt >= FAULT_TICKS)
                up_fault = 1'b1;
            else
                up_stuck_cnt = up_stuck_cnt + 1'b1;
        end
        else begin
            up_stuck_cnt = '0;
            up_fault     = 1'b0;
        end

        fw = (fw_in > CLIP_LEVEL) ? CLIP_LEVEL : fw_in;
        up = (up_in > CLIP_LEVEL) ? CLIP_LEVEL : up_in;

        if (up <= UP_LOW_LIMIT) begin
            on_th  = {1'b0, lamp_cfg.on_th};
            off_th = {1'b0, lamp_cfg.off_th};
        end
        else if (up <= UP_MID_LIMIT) begin
            on_th  = {1'b0, lamp_cfg.on_th} + STEP_MID;
            off_th = {1'b0, lamp_cfg.off_th} + STEP_MID;
        end
        else begin
            on_th  = {1'b0, lamp_cfg.on_th} + STEP_HIGH;
            off_th = {1'b0, lamp_cfg.off_th} + STEP_HIGH;
        end

        if (!up_fault) begin
            dark   = ({1'b0, fw} <= on_th) && (up <= UP_LOW_LIMIT);
            bright = (({1'b0, fw} > off_th) && (up > UP_BRIGHT_MIN)) || (fw > FW_BRIGHT_ABS);
        end
        else begin
            dark   = {1'b0, fw} <= on_th;
            bright = {1'b0, fw} > off_th;
        end

        g       = (gear_in > TOP_GEAR) ? TOP_GEAR : gear_in;
        on_wait = lamp_cfg.on_delay[g];

        if (dark) begin
            bright_run = '0;
            if (dark_run >= on_wait)
                beam_on = 1'b1;
            else
                dark_run = dark_run + 1'b1;
        end
        else if (bright) begin
            dark_run = '0;
            if (bright_run >= lamp_cfg.off_delay)
                beam_on = 1'b0;
            else
                bright_run = bright_run + 1'b1;
        end
        else begin
            dark_run   = '0;
            bright_run = '0;
        end

        res = {5'b0, up_fault, fw_fault, beam_on};
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (err_cnt < REPORT_CAP)
            $display("MISMATCH %s: got %0h, expected %0h", what, got, want);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------
    // monitor: results checked against the oldest expectation; accepted
    // input beats run through the predictor
    // ------------------------------------------------------------------
    logic [7:0] pred_res;
    logic [7:0] want_res;
    pinned_t    pin;

    always @(posedge clk) begin
        if (rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (lamp_exp_q.size() == 0) begin
                    report_mismatch("result beat with nothing expected", m_axis_tdata, 8'h00);
                end
                else begin
                    want_res = lamp_exp_q.pop_front();
                    if (m_axis_tdata[0] !== want_res[0])
                        report_mismatch("light_request", m_axis_tdata, want_res);
                    if (m_axis_tdata[1] !== want_res[1])
                        report_mismatch("forward_fault", m_axis_tdata, want_res);
                    if (m_axis_tdata[2] !== want_res[2])
                        report_mismatch("upward_fault", m_axis_tdata, want_res);
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                headlamp_step(s_axis_tdata[11:0], s_axis_tdata[23:12],
                              s_axis_tdata[26:24], pred_res);
                pin = pinned_q.pop_front();
                lamp_exp_q.push_back(pin.fixed ? pin.res : pred_res);
            end
        end
    end

    // watchdog: ends the run when no beat of any channel moves for too long
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // receiver: random back-pressure, plus a long hold-off on request
    initial begin
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            if (rx_hold_left != 0) begin
                m_axis_tready <= 1'b0;
                rx_hold_left = rx_hold_left - 1;
            end
            else begin
                m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // driving tasks
    // ------------------------------------------------------------------

    // one input beat; tvalid stays high into the next beat unless a gap falls
    task automatic send_beat(input logic [31:0] data, input pinned_t p);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        pinned_q.push_back(p);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_OFF_DELAY: lamp_cfg.off_delay = val[7:0];
            REG_ON_TH:     lamp_cfg.on_th     = val;
            REG_OFF_TH:    lamp_cfg.off_th    = val;
            default:       lamp_cfg.on_delay[idx - REG_ON_GEAR0] = val[7:0];
        endcase
    endtask

    // writes all eight registers; upper nibble of 8-bit registers is junk
    task automatic load_setting(input setting_t s);
        cfg_t       c;
        logic [3:0] pad;

        c = CFG_RESET;
        case (s)
            SET_ZERO:    c = '0;
            SET_MAX:     c = '1;
            SET_DEFAULT: c = CFG_RESET;
            SET_MODERATE: begin
                c.off_delay = 8'($urandom_range(40));
                c.on_th     = 12'($urandom_range(400, 50));
                c.off_th    = 12'(c.on_th + $urandom_range(200));
                for (int i = 0; i < GEARS; i++)
                    c.on_delay[i] = 8'($urandom_range(30));
            end
            default: begin
                c.off_delay = 8'($urandom_range(255));
                c.on_th     = 12'($urandom_range(4095));
                c.off_th    = 12'($urandom_range(4095));
                for (int i = 0; i < GEARS; i++)
                    c.on_delay[i] = 8'($urandom_range(255));
            end
        endcase
        pad = (s == SET_MAX) ? 4'hF : 4'($urandom_range(15));
        write_reg(REG_OFF_DELAY, {pad, c.off_delay});
        write_reg(REG_ON_TH,     c.on_th);
        write_reg(REG_OFF_TH,    c.off_th);
        write_reg(REG_ON_GEAR0,  {pad, c.on_delay[0]});
        write_reg(REG_ON_GEAR1,  {pad, c.on_delay[1]});
        write_reg(REG_ON_GEAR2,  {pad, c.on_delay[2]});
        write_reg(REG_ON_GEAR3,  {pad, c.on_delay[3]});
        write_reg(REG_ON_GEAR4,  {pad, c.on_delay[4]});
        cfg_valid <= 1'b0;
    endtask

    // waits for the clock first, so the monitor has queued the last accepted beat
    task automatic wait_drained;
        @(posedge clk);
        while (lamp_exp_q.size() != 0)
            @(posedge clk);
    endtask

    // one random beat of the given run kind, shaped by the current registers
    function automatic logic [31:0] make_beat(input run_kind_t kind, input logic [2:0] gear);
        logic [11:0] fw;
        logic [11:0] up;
        logic [2:0]  g;
        int          lo;

        fw = 12'($urandom_range(4095));
        up = 12'($urandom_range(4095));
        g  = gear;
        case (kind)
            RUN_DARK: begin
                up = 12'($urandom_range(UP_LOW_LIMIT));
                fw = 12'($urandom_range(lamp_cfg.on_th));
            end
            RUN_BRIGHT: begin
                if ($urandom_range(1)) begin
                    fw = 12'($urandom_range(4095, FW_BRIGHT_ABS + 1));
                end
                else begin
                    up = 12'($urandom_range(4094, UP_BRIGHT_MIN + 1));
                    lo = lamp_cfg.off_th + 21;
                    if (lo > 4095)
                        lo = 4095;
                    fw = 12'($urandom_range(4095, lo));
                end
            end
            RUN_DIM: begin
                // somewhere between the two thresholds: often neither
                up = 12'($urandom_range(120));
                lo = lamp_cfg.off_th + 20;
                if (lo > 4095)
                    lo = 4095;
                fw = 12'($urandom_range(lo, lamp_cfg.on_th));
            end
            RUN_STUCK_FW: fw = FULL_SCALE;
            RUN_STUCK_UP: begin
                up = FULL_SCALE;
                if ($urandom_range(1)) begin
                    lo = lamp_cfg.on_th + 20;
                    if (lo > 4095)
                        lo = 4095;
                    fw = 12'($urandom_range(lo));
                end
            end
            default: g = 3'($urandom_range(7));
        endcase
        return {5'b0, g, up, fw};
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    setting_t plan [0:PHASES-1] = '{SET_MODERATE, SET_ZERO, SET_MAX,
                                    SET_DEFAULT, SET_WIDE, SET_MODERATE};

    initial begin
        run_kind_t  kind;
        logic [2:0] run_gear;
        logic [2:0] g_eff;
        int         run_left;
        int         pick;

        clk           = 1'b0;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        kind          = RUN_NOISE;
        run_gear      = '0;
        run_left      = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at the reset register values
        tx_idle_pct = 7;
        rx_idle_pct = 66;
        foreach (dir_tab[r]) begin
            for (int n = 0; n < dir_tab[r].reps; n++)
                send_beat({5'b0, dir_tab[r].gear, dir_tab[r].up, dir_tab[r].fw},
                          '{dir_tab[r].fixed, dir_tab[r].res});
        end
        s_axis_tvalid <= 1'b0;
        wait_drained();

        for (int ph = 0; ph < PHASES; ph++) begin
            // registers only change once the pipe is empty
            load_setting(plan[ph]);
            if (ph < 2) begin
                tx_idle_pct = 7;
                rx_idle_pct = 66;
            end
            else if (ph < 4) begin
                tx_idle_pct = 66;
                rx_idle_pct = 7;
            end
            else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            for (int b = 0; b < PHASE_BEATS; b++) begin
                // long receiver hold-off while the sender keeps offering
                if (ph == 4 && b == 100)
                    rx_hold_left = HOLD_CYCLES;

                if (run_left == 0) begin
                    pick     = $urandom_range(99);
                    run_gear = 3'($urandom_range(7));
                    g_eff    = (run_gear > TOP_GEAR) ? TOP_GEAR : run_gear;
                    if (pick < 30)
                        kind = RUN_DARK;
                    else if (pick < 60)
                        kind = RUN_BRIGHT;
                    else if (pick < 65)
                        kind = RUN_STUCK_FW;
                    else if (pick < 70)
                        kind = RUN_STUCK_UP;
                    else if (pick < 80)
                        kind = RUN_DIM;
                    else
                        kind = RUN_NOISE;
                    case (kind)
                        // half the runs just outlast the debounce delay
                        RUN_DARK:
                            run_left = $urandom_range(1) ?
                                       lamp_cfg.on_delay[g_eff] + $urandom_range(4, 1) :
                                       $urandom_range(12, 1);
                        RUN_BRIGHT:
                            run_left = $urandom_range(1) ?
                                       lamp_cfg.off_delay + $urandom_range(4, 1) :
                                       $urandom_range(12, 1);
                        RUN_STUCK_FW, RUN_STUCK_UP:
                            run_left = $urandom_range(60, 45);
                        default:
                            run_left = $urandom_range(8, 1);
                    endcase
                end
                send_beat(make_beat(kind, run_gear), '{1'b0, 8'h00});
                run_left = run_left - 1;
            end
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_cnt == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> files.f
design/ahlr_pkg.sv
design/ahlr_cfg_regs.sv
design/ahlr_fault.sv
design/ahlr_decide.sv
design/auto_headlamp_light_request.sv
bench/tb.sv
